>>> sv/rbi_pkg.sv
// shared types, constants and codes of the rigid body inertia block
package rbi_pkg;

	// fixed point format of inputs and results
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;
	localparam int Q_W       = 48;

	// datapath widths
	localparam int SQ_W    = 2 * IN_W;
	localparam int CUBE_W  = 3 * IN_W;
	localparam int V_W     = CUBE_W + 7;
	localparam int LIMBS   = 4;
	localparam int VP_W    = LIMBS * IN_W;
	localparam int PP_W    = 2 * IN_W;
	localparam int NUM_W   = V_W + IN_W;
	localparam int M_W     = NUM_W + 2;
	localparam int SH      = 2 * FRAC_BITS + 1;
	localparam int MS_W    = M_W - SH;
	localparam int HI_W    = MS_W - Q_W;
	localparam int D_W     = IN_W + 3;
	localparam int DEN_W   = D_W + 5;
	localparam int LANES   = 3;
	localparam int NCELL   = Q_W;

	// output buffer
	localparam int BUF_DEPTH = 2;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

	typedef logic [IN_W-1:0]  word32_t;
	typedef logic [SQ_W-1:0]  sq_t;
	typedef logic [SQ_W:0]    sqsum_t;
	typedef logic [CUBE_W-1:0] cube_t;
	typedef logic [V_W-1:0]   v_t;
	typedef logic [VP_W-1:0]  vp_t;
	typedef logic [PP_W-1:0]  pp_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [M_W-1:0]   m_t;
	typedef logic [MS_W-1:0]  ms_t;
	typedef logic [HI_W-1:0]  hi_t;
	typedef logic [D_W-1:0]   d_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [DEN_W:0]   dent_t;
	typedef logic [Q_W-1:0]   q_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam q_t   OUT_MAX    = {Q_W{1'b1}};
	localparam den_t BOX_DEN    = den_t'(12);
	localparam den_t SPHERE_DEN = den_t'(5);

	typedef enum logic [1:0] {
		SHAPE_BOX     = 2'd0,
		SHAPE_CAPSULE = 2'd1,
		SHAPE_SPHERE  = 2'd2,
		SHAPE_BAD     = 2'd3
	} shape_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SHAPE = 2'd1,
		ST_DEGEN     = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	// one input request
	typedef struct packed {
		logic [1:0] shape_kind;
		word32_t    mass;
		word32_t    size_x;
		word32_t    size_y;
		word32_t    size_z;
		word32_t    radius;
		word32_t    cyl_height;
	} in_item_t;

	// one lane of the divider chain
	typedef struct packed {
		den_t rem;
		q_t   dvd;
		q_t   quo;
		den_t den;
		logic sat;
	} div_lane_t;

	// word handed from cell to cell
	typedef struct packed {
		logic                  vld;
		status_t               st;
		div_lane_t [LANES-1:0] lane;
	} div_word_t;

	// finished result
	typedef struct packed {
		q_t      inertia_x;
		q_t      inertia_y;
		q_t      inertia_z;
		status_t status;
	} res_t;

endpackage

>>> sv/rbi_in_if.sv
// input request channel of the inertia block
interface rbi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  shape_kind;
	logic [31:0] mass;
	logic [31:0] size_x;
	logic [31:0] size_y;
	logic [31:0] size_z;
	logic [31:0] radius;
	logic [31:0] cyl_height;

	modport source (output valid, shape_kind, mass, size_x, size_y, size_z, radius,
		cyl_height, input ready);
	modport sink (input valid, shape_kind, mass, size_x, size_y, size_z, radius,
		cyl_height, output ready);
endinterface

>>> sv/rbi_out_if.sv
// result channel of the inertia block
interface rbi_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] inertia_x;
	logic [47:0] inertia_y;
	logic [47:0] inertia_z;
	logic [1:0]  status;

	modport source (output valid, inertia_x, inertia_y, inertia_z, status, input ready);
	modport sink (input valid, inertia_x, inertia_y, inertia_z, status, output ready);
endinterface

>>> sv/rbi_front.sv
// front pipeline: squares, cubes, lane numerators and divider setup
module rbi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  rbi_pkg::in_item_t  item,
	output rbi_pkg::div_word_t word
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// stage 1
	rbi_pkg::sq_t     xx_s1, yy_s1, zz_s1, rr_s1, hh_s1;
	rbi_pkg::word32_t h_s1, r_s1, m_s1;
	rbi_pkg::d_t      d_s1;
	rbi_pkg::shape_t  kind_s1;

	// stage 2
	rbi_pkg::pp_t     hhh_lo_s2, hhh_hi_s2, hhr_lo_s2, hhr_hi_s2;
	rbi_pkg::pp_t     rrh_lo_s2, rrh_hi_s2, rrr_lo_s2, rrr_hi_s2;
	rbi_pkg::sqsum_t  bx_s2, by_s2, bz_s2, sp_s2;
	rbi_pkg::word32_t m_s2;
	rbi_pkg::d_t      d_s2;
	rbi_pkg::shape_t  kind_s2;

	// stage 3
	rbi_pkg::cube_t   hhh_s3, hhr_s3, rrh_s3, rrr_s3;
	rbi_pkg::sqsum_t  bx_s3, by_s3, bz_s3, sp_s3;
	rbi_pkg::word32_t m_s3;
	rbi_pkg::d_t      d_s3;
	rbi_pkg::shape_t  kind_s3;

	// stage 4
	rbi_pkg::v_t      a_s4, b_s4, c_s4;
	rbi_pkg::sqsum_t  bx_s4, by_s4, bz_s4, sp_s4;
	rbi_pkg::word32_t m_s4;
	rbi_pkg::shape_t  kind_s4;
	rbi_pkg::den_t    den_s4 [rbi_pkg::LANES];
	rbi_pkg::status_t st_s4;
	rbi_pkg::den_t    den_c [rbi_pkg::LANES];
	rbi_pkg::status_t st_c;

	// stage 5
	rbi_pkg::v_t      v_s5 [rbi_pkg::LANES];
	rbi_pkg::word32_t m_s5;
	rbi_pkg::den_t    den_s5 [rbi_pkg::LANES];
	rbi_pkg::status_t st_s5;

	// stage 6
	rbi_pkg::vp_t     vpad_c [rbi_pkg::LANES];
	rbi_pkg::pp_t     p_s6 [rbi_pkg::LANES][rbi_pkg::LIMBS];
	rbi_pkg::den_t    den_s6 [rbi_pkg::LANES];
	rbi_pkg::status_t st_s6;

	// stage 7
	rbi_pkg::num_t    num_c [rbi_pkg::LANES];
	rbi_pkg::num_t    num_s7 [rbi_pkg::LANES];
	rbi_pkg::den_t    den_s7 [rbi_pkg::LANES];
	rbi_pkg::status_t st_s7;

	// stage 8
	rbi_pkg::m_t        mv_c [rbi_pkg::LANES];
	rbi_pkg::ms_t       ms_c [rbi_pkg::LANES];
	rbi_pkg::hi_t       hi_c [rbi_pkg::LANES];
	rbi_pkg::div_word_t word_c;
	rbi_pkg::div_word_t word_s8;

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// squares and capsule length sum
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1   <= rbi_pkg::sq_t'(item.size_x) * rbi_pkg::sq_t'(item.size_x);
			yy_s1   <= rbi_pkg::sq_t'(item.size_y) * rbi_pkg::sq_t'(item.size_y);
			zz_s1   <= rbi_pkg::sq_t'(item.size_z) * rbi_pkg::sq_t'(item.size_z);
			rr_s1   <= rbi_pkg::sq_t'(item.radius) * rbi_pkg::sq_t'(item.radius);
			hh_s1   <= rbi_pkg::sq_t'(item.cyl_height) * rbi_pkg::sq_t'(item.cyl_height);
			d_s1    <= rbi_pkg::d_t'(item.cyl_height) + (rbi_pkg::d_t'(item.cyl_height) << 1)
				+ (rbi_pkg::d_t'(item.radius) << 2);
			h_s1    <= item.cyl_height;
			r_s1    <= item.radius;
			m_s1    <= item.mass;
			kind_s1 <= rbi_pkg::shape_t'(item.shape_kind);
		end
	end

	// cube partial products and box sums
	always_ff @(posedge clk) begin
		if (en) begin
			hhh_lo_s2 <= rbi_pkg::pp_t'(hh_s1[31:0]) * rbi_pkg::pp_t'(h_s1);
			hhh_hi_s2 <= rbi_pkg::pp_t'(hh_s1[63:32]) * rbi_pkg::pp_t'(h_s1);
			hhr_lo_s2 <= rbi_pkg::pp_t'(hh_s1[31:0]) * rbi_pkg::pp_t'(r_s1);
			hhr_hi_s2 <= rbi_pkg::pp_t'(hh_s1[63:32]) * rbi_pkg::pp_t'(r_s1);
			rrh_lo_s2 <= rbi_pkg::pp_t'(rr_s1[31:0]) * rbi_pkg::pp_t'(h_s1);
			rrh_hi_s2 <= rbi_pkg::pp_t'(rr_s1[63:32]) * rbi_pkg::pp_t'(h_s1);
			rrr_lo_s2 <= rbi_pkg::pp_t'(rr_s1[31:0]) * rbi_pkg::pp_t'(r_s1);
			rrr_hi_s2 <= rbi_pkg::pp_t'(rr_s1[63:32]) * rbi_pkg::pp_t'(r_s1);
			bx_s2     <= rbi_pkg::sqsum_t'(yy_s1) + rbi_pkg::sqsum_t'(zz_s1);
			by_s2     <= rbi_pkg::sqsum_t'(xx_s1) + rbi_pkg::sqsum_t'(zz_s1);
			bz_s2     <= rbi_pkg::sqsum_t'(xx_s1) + rbi_pkg::sqsum_t'(yy_s1);
			sp_s2     <= {rr_s1, 1'b0};
			m_s2      <= m_s1;
			d_s2      <= d_s1;
			kind_s2   <= kind_s1;
		end
	end

	// cubes
	always_ff @(posedge clk) begin
		if (en) begin
			hhh_s3  <= rbi_pkg::cube_t'(hhh_lo_s2) + (rbi_pkg::cube_t'(hhh_hi_s2) << rbi_pkg::IN_W);
			hhr_s3  <= rbi_pkg::cube_t'(hhr_lo_s2) + (rbi_pkg::cube_t'(hhr_hi_s2) << rbi_pkg::IN_W);
			rrh_s3  <= rbi_pkg::cube_t'(rrh_lo_s2) + (rbi_pkg::cube_t'(rrh_hi_s2) << rbi_pkg::IN_W);
			rrr_s3  <= rbi_pkg::cube_t'(rrr_lo_s2) + (rbi_pkg::cube_t'(rrr_hi_s2) << rbi_pkg::IN_W);
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;
			bz_s3   <= bz_s2;
			sp_s3   <= sp_s2;
			m_s3    <= m_s2;
			d_s3    <= d_s2;
			kind_s3 <= kind_s2;
		end
	end

	// divisors and status per shape
	always_comb begin
		st_c = rbi_pkg::ST_OK;
		for (int l = 0; l < rbi_pkg::LANES; l++) begin
			den_c[l] = '0;
		end
		case (kind_s3)
			rbi_pkg::SHAPE_BOX: begin
				for (int l = 0; l < rbi_pkg::LANES; l++) begin
					den_c[l] = rbi_pkg::BOX_DEN;
				end
			end
			rbi_pkg::SHAPE_SPHERE: begin
				for (int l = 0; l < rbi_pkg::LANES; l++) begin
					den_c[l] = rbi_pkg::SPHERE_DEN;
				end
			end
			rbi_pkg::SHAPE_CAPSULE: begin
				den_c[0] = (rbi_pkg::den_t'(d_s3) << 4) + (rbi_pkg::den_t'(d_s3) << 2);
				den_c[1] = (rbi_pkg::den_t'(d_s3) << 3) + (rbi_pkg::den_t'(d_s3) << 1);
				den_c[2] = den_c[0];
				if (d_s3 == '0) begin
					st_c = rbi_pkg::ST_DEGEN;
				end
			end
			default: begin
				st_c = rbi_pkg::ST_BAD_SHAPE;
			end
		endcase
	end

	// capsule polynomial terms
	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= (rbi_pkg::v_t'(hhh_s3) << 2) + rbi_pkg::v_t'(hhh_s3)
				+ (rbi_pkg::v_t'(hhr_s3) << 4) + (rbi_pkg::v_t'(hhr_s3) << 2);
			b_s4 <= (rbi_pkg::v_t'(rrh_s3) << 5) + (rbi_pkg::v_t'(rrh_s3) << 3)
				+ (rbi_pkg::v_t'(rrh_s3) << 2) + rbi_pkg::v_t'(rrh_s3)
				+ (rbi_pkg::v_t'(rrr_s3) << 5);
			c_s4 <= (rbi_pkg::v_t'(rrh_s3) << 4) - rbi_pkg::v_t'(rrh_s3)
				+ (rbi_pkg::v_t'(rrr_s3) << 4);
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;
			bz_s4   <= bz_s3;
			sp_s4   <= sp_s3;
			m_s4    <= m_s3;
			kind_s4 <= kind_s3;
			st_s4   <= st_c;
			for (int l = 0; l < rbi_pkg::LANES; l++) begin
				den_s4[l] <= den_c[l];
			end
		end
	end

	// lane numerators before the mass
	always_ff @(posedge clk) begin
		if (en) begin
			case (kind_s4)
				rbi_pkg::SHAPE_BOX: begin
					v_s5[0] <= rbi_pkg::v_t'(bx_s4);
					v_s5[1] <= rbi_pkg::v_t'(by_s4);
					v_s5[2] <= rbi_pkg::v_t'(bz_s4);
				end
				rbi_pkg::SHAPE_SPHERE: begin
					v_s5[0] <= rbi_pkg::v_t'(sp_s4);
					v_s5[1] <= rbi_pkg::v_t'(sp_s4);
					v_s5[2] <= rbi_pkg::v_t'(sp_s4);
				end
				rbi_pkg::SHAPE_CAPSULE: begin
					v_s5[0] <= a_s4 + b_s4;
					v_s5[1] <= c_s4;
					v_s5[2] <= a_s4 + b_s4;
				end
				default: begin
					v_s5[0] <= '0;
					v_s5[1] <= '0;
					v_s5[2] <= '0;
				end
			endcase
			m_s5  <= m_s4;
			st_s5 <= st_s4;
			for (int l = 0; l < rbi_pkg::LANES; l++) begin
				den_s5[l] <= den_s4[l];
			end
		end
	end

	// mass partial products, one 32 bit limb each
	always_comb begin
		for (int l = 0; l < rbi_pkg::LANES; l++) begin
			vpad_c[l] = rbi_pkg::vp_t'(v_s5[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbi_pkg::LANES; l++) begin
				for (int k = 0; k < rbi_pkg::LIMBS; k++) begin
					p_s6[l][k] <= rbi_pkg::pp_t'(vpad_c[l][k*rbi_pkg::IN_W +: rbi_pkg::IN_W])
						* rbi_pkg::pp_t'(m_s5);
				end
				den_s6[l] <= den_s5[l];
			end
			st_s6 <= st_s5;
		end
	end

	// full numerators
	always_comb begin
		for (int l = 0; l < rbi_pkg::LANES; l++) begin
			num_c[l] = '0;
			for (int k = 0; k < rbi_pkg::LIMBS; k++) begin
				num_c[l] = num_c[l] + (rbi_pkg::num_t'(p_s6[l][k]) << (k * rbi_pkg::IN_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbi_pkg::LANES; l++) begin
				num_s7[l] <= num_c[l];
				den_s7[l] <= den_s6[l];
			end
			st_s7 <= st_s6;
		end
	end

	// rounding offset, scaling and overflow check
	always_comb begin
		word_c     = '0;
		word_c.vld = vld_s7;
		word_c.st  = st_s7;
		for (int l = 0; l < rbi_pkg::LANES; l++) begin
			mv_c[l] = (rbi_pkg::m_t'(num_s7[l]) << 1)
				+ (rbi_pkg::m_t'(den_s7[l]) << (2 * rbi_pkg::FRAC_BITS));
			ms_c[l] = rbi_pkg::ms_t'(mv_c[l] >> rbi_pkg::SH);
			hi_c[l] = ms_c[l][rbi_pkg::MS_W-1:rbi_pkg::Q_W];
			word_c.lane[l].den = den_s7[l];
			word_c.lane[l].dvd = ms_c[l][rbi_pkg::Q_W-1:0];
			word_c.lane[l].quo = '0;
			word_c.lane[l].sat = (hi_c[l] >= rbi_pkg::hi_t'(den_s7[l]));
			word_c.lane[l].rem = word_c.lane[l].sat ? '0
				: rbi_pkg::den_t'(hi_c[l][rbi_pkg::DEN_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s8 <= word_c;
		end
	end

	always_comb begin
		word     = word_s8;
		word.vld = vld_s8;
	end

endmodule

>>> sv/rbi_div_cell.sv
// one restoring division step for all three lanes
module rbi_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  rbi_pkg::div_word_t d,
	output rbi_pkg::div_word_t q
);

	rbi_pkg::div_word_t nxt;
	rbi_pkg::div_word_t word_s1;
	rbi_pkg::dent_t     t [rbi_pkg::LANES];
	logic               qbit [rbi_pkg::LANES];
	logic               vld_s1;

	// shift in the next dividend bit and try to subtract
	always_comb begin
		nxt = d;
		for (int l = 0; l < rbi_pkg::LANES; l++) begin
			t[l]    = {d.lane[l].rem, d.lane[l].dvd[rbi_pkg::Q_W-1]};
			qbit[l] = (t[l] >= {1'b0, d.lane[l].den});
			if (qbit[l]) begin
				nxt.lane[l].rem = rbi_pkg::den_t'(t[l] - {1'b0, d.lane[l].den});
			end else begin
				nxt.lane[l].rem = t[l][rbi_pkg::DEN_W-1:0];
			end
			nxt.lane[l].dvd = {d.lane[l].dvd[rbi_pkg::Q_W-2:0], 1'b0};
			nxt.lane[l].quo = {d.lane[l].quo[rbi_pkg::Q_W-2:0], qbit[l]};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

	always_comb begin
		q     = word_s1;
		q.vld = vld_s1;
	end

endmodule

>>> sv/rbi_out_buf.sv
// two-entry result buffer between the pipeline and the result channel
module rbi_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rbi_pkg::res_t wr,
	input  logic          take,
	output logic          vld,
	output rbi_pkg::res_t rd,
	output logic          room
);

	rbi_pkg::res_t ent_q [rbi_pkg::BUF_DEPTH];
	rbi_pkg::cnt_t cnt_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic          pop;

	assign vld  = (cnt_q != '0);
	assign pop  = take && vld;
	assign room = (cnt_q != rbi_pkg::cnt_t'(rbi_pkg::BUF_DEPTH));
	assign rd   = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr;
		end
	end

endmodule

>>> sv/rigid_body_inertia_calc_top.sv
// top level of the rigid body principal inertia block
//
// in_ch takes one request per cycle: shape code (box, capsule, sphere),
// mass and sizes in unsigned Q16.16. out_ch returns the three principal
// moments in unsigned Q32.16 and a status code, one result per request,
// in request order.
// A result passes eight front stages (squares, cubes, polynomial, mass
// products, numerator sum, scaling), a chain of 48 division cells, one
// quotient bit per cell, then one register in the two-entry result buffer.
// Throughput is one request per cycle. in_ch.ready is high while the
// result buffer is not full, so a request is still taken while one
// result waits; when both entries wait, the whole pipeline holds.
// Reset clears all valid bits and the buffer; no result is pending
// afterwards.
module rigid_body_inertia_calc_top (
	input logic      clk,
	input logic      arst_n,
	rbi_in_if.sink   in_ch,
	rbi_out_if.source out_ch
);

	rbi_pkg::in_item_t  item;
	rbi_pkg::div_word_t chain_w [rbi_pkg::NCELL+1];
	rbi_pkg::div_word_t last_w;
	rbi_pkg::res_t      res_c;
	rbi_pkg::res_t      rd;
	logic               adv;
	logic               any_sat;

	assign in_ch.ready = adv;

	// request payload
	assign item.shape_kind = in_ch.shape_kind;
	assign item.mass       = in_ch.mass;
	assign item.size_x     = in_ch.size_x;
	assign item.size_y     = in_ch.size_y;
	assign item.size_z     = in_ch.size_z;
	assign item.radius     = in_ch.radius;
	assign item.cyl_height = in_ch.cyl_height;

	rbi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (in_ch.valid),
		.item   (item),
		.word   (chain_w[0])
	);

	// division chain
	for (genvar i = 0; i < rbi_pkg::NCELL; i++) begin : g_cell
		rbi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain_w[i]),
			.q      (chain_w[i+1])
		);
	end

	assign last_w = chain_w[rbi_pkg::NCELL];

	// saturation, zero forcing and final status
	always_comb begin
		any_sat = last_w.lane[0].sat || last_w.lane[1].sat || last_w.lane[2].sat;
		if (last_w.st != rbi_pkg::ST_OK) begin
			res_c.inertia_x = '0;
			res_c.inertia_y = '0;
			res_c.inertia_z = '0;
			res_c.status    = last_w.st;
		end else begin
			res_c.inertia_x = last_w.lane[0].sat ? rbi_pkg::OUT_MAX : last_w.lane[0].quo;
			res_c.inertia_y = last_w.lane[1].sat ? rbi_pkg::OUT_MAX : last_w.lane[1].quo;
			res_c.inertia_z = last_w.lane[2].sat ? rbi_pkg::OUT_MAX : last_w.lane[2].quo;
			res_c.status    = any_sat ? rbi_pkg::ST_SAT : rbi_pkg::ST_OK;
		end
	end

	rbi_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv && last_w.vld),
		.wr     (res_c),
		.take   (out_ch.ready),
		.vld    (out_ch.valid),
		.rd     (rd),
		.room   (adv)
	);

	assign out_ch.inertia_x = rd.inertia_x;
	assign out_ch.inertia_y = rd.inertia_y;
	assign out_ch.inertia_z = rd.inertia_z;
	assign out_ch.status    = rd.status;

endmodule

>>> sim/rigid_body_inertia_calc_top_tb.sv
// testbench of the rigid body inertia block: directed and random requests against a predictor
`timescale 1ns / 1ps
module rigid_body_inertia_calc_top_tb;

	localparam int LATENCY   = 57;
	localparam int MAX_CYCLE = 400000;
	localparam int EXP_DEPTH = 256;

	logic clk;
	logic arst_n;

	rbi_in_if  in_ch ();
	rbi_out_if out_ch ();

	rigid_body_inertia_calc_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	rbi_pkg::res_t expected_moments [EXP_DEPTH];
	int   exp_wr;
	int   exp_rd;
	int   error_count;
	int   request_count;
	int   result_count;
	int   sat_count;
	int   cycle_count;
	int   out_wait;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// exact rounded quotient num / (den << 2F), ties up, with saturation
	function automatic rbi_pkg::q_t scaled_quotient(input logic [255:0] num,
			input logic [63:0] den, inout logic sat);
		logic [255:0] d;
		logic [255:0] q;
		d = {192'd0, den} << (2 * rbi_pkg::FRAC_BITS);
		q = ((num << 1) + d) / (d << 1);
		if (q > {208'd0, rbi_pkg::OUT_MAX}) begin
			sat = 1'b1;
			return rbi_pkg::OUT_MAX;
		end
		return q[rbi_pkg::Q_W-1:0];
	endfunction

	// box moment about one axis from the two other edges
	function automatic rbi_pkg::q_t box_moment(input logic [31:0] m, input logic [31:0] p,
			input logic [31:0] q, inout logic sat);
		logic [255:0] n;
		n = (256'(p) * p + 256'(q) * q) * m;
		return scaled_quotient(n, 64'd12, sat);
	endfunction

	// predicted moments of one request
	function automatic rbi_pkg::res_t predict_moments(input rbi_pkg::in_item_t it);
		rbi_pkg::res_t r;
		logic          sat;
		logic [255:0]  m, h, rd, n, d;
		r   = '0;
		sat = 1'b0;
		m   = 256'(it.mass);
		h   = 256'(it.cyl_height);
		rd  = 256'(it.radius);
		case (rbi_pkg::shape_t'(it.shape_kind))
			rbi_pkg::SHAPE_BOX: begin
				r.inertia_x = box_moment(it.mass, it.size_y, it.size_z, sat);
				r.inertia_y = box_moment(it.mass, it.size_x, it.size_z, sat);
				r.inertia_z = box_moment(it.mass, it.size_x, it.size_y, sat);
				r.status    = sat ? rbi_pkg::ST_SAT : rbi_pkg::ST_OK;
			end
			rbi_pkg::SHAPE_SPHERE: begin
				r.inertia_x = scaled_quotient(rd * rd * m * 2, 64'd5, sat);
				r.inertia_y = r.inertia_x;
				r.inertia_z = r.inertia_x;
				r.status    = sat ? rbi_pkg::ST_SAT : rbi_pkg::ST_OK;
			end
			rbi_pkg::SHAPE_CAPSULE: begin
				d = 3 * h + 4 * rd;
				if (d == 0) begin
					r.status = rbi_pkg::ST_DEGEN;
				end else begin
					n = (5 * h * h * h + 20 * rd * h * h + 45 * h * rd * rd
						+ 32 * rd * rd * rd) * m;
					r.inertia_x = scaled_quotient(n, 64'(20 * d), sat);
					r.inertia_z = r.inertia_x;
					n = rd * rd * (15 * h + 16 * rd) * m;
					r.inertia_y = scaled_quotient(n, 64'(10 * d), sat);
					r.status    = sat ? rbi_pkg::ST_SAT : rbi_pkg::ST_OK;
				end
			end
			default: r.status = rbi_pkg::ST_BAD_SHAPE;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	// send one request after a random gap
	task automatic send_request(input rbi_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.shape_kind <= it.shape_kind;
		in_ch.mass       <= it.mass;
		in_ch.size_x     <= it.size_x;
		in_ch.size_y     <= it.size_y;
		in_ch.size_z     <= it.size_z;
		in_ch.radius     <= it.radius;
		in_ch.cyl_height <= it.cyl_height;
		do @(posedge clk); while (!in_ch.ready);
		expected_moments[exp_wr % EXP_DEPTH] = predict_moments(it);
		exp_wr++;
		request_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		rbi_pkg::res_t want;
		if (out_ch.valid && out_ch.ready) begin
			result_count++;
			if (exp_wr == exp_rd) begin
				report_mismatch("unexpected result", out_ch.inertia_x, 48'd0);
			end else begin
				want = expected_moments[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (want.status == rbi_pkg::ST_SAT)
					sat_count++;
				if (out_ch.inertia_x !== want.inertia_x)
					report_mismatch("inertia_x", out_ch.inertia_x, want.inertia_x);
				if (out_ch.inertia_y !== want.inertia_y)
					report_mismatch("inertia_y", out_ch.inertia_y, want.inertia_y);
				if (out_ch.inertia_z !== want.inertia_z)
					report_mismatch("inertia_z", out_ch.inertia_z, want.inertia_z);
				if (out_ch.status !== want.status)
					report_mismatch("status", 48'(out_ch.status), 48'(want.status));
			end
		end
	end

	// receiver draws a random wait after each taken result and holds ready low until it has counted down
	always @(posedge clk) begin
		if (!arst_n) begin
			out_wait = 0;
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				out_wait = $urandom_range(0, 5);
			else if (out_ch.valid && out_wait > 0)
				out_wait--;
			out_ch.ready <= (out_wait == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLE) begin
			$display("timeout with %0d results outstanding", exp_wr - exp_rd);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] random_word(input int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0001_0000 * 16);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return $urandom_range(0, 32'h0000_4000);
		endcase
	endfunction

	function automatic rbi_pkg::in_item_t random_request(input logic [1:0] shape);
		rbi_pkg::in_item_t it;
		it.shape_kind = shape;
		it.mass       = random_word($urandom_range(0, 3));
		it.size_x     = random_word($urandom_range(0, 3));
		it.size_y     = random_word($urandom_range(0, 3));
		it.size_z     = random_word($urandom_range(0, 3));
		it.radius     = random_word($urandom_range(0, 3));
		it.cyl_height = random_word($urandom_range(0, 3));
		if (shape == rbi_pkg::SHAPE_CAPSULE && $urandom_range(0, 15) == 0) begin
			it.radius = '0;
			if ($urandom_range(0, 1) == 0)
				it.cyl_height = '0;
		end
		return it;
	endfunction

	// field extremes for every shape, plus degenerate and invalid cases
	task automatic test_directed();
		rbi_pkg::in_item_t it;
		for (int s = 0; s < 4; s++) begin
			it = '0;
			it.shape_kind = 2'(s);
			send_request(it);
			it = '1;
			it.shape_kind = 2'(s);
			send_request(it);
			it = '{2'(s), 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
				32'h0001_0000, 32'h0002_0000};
			send_request(it);
		end
		// capsule with only one of radius and height
		it = '{rbi_pkg::SHAPE_CAPSULE, 32'h0001_0000, 0, 0, 0, 32'h0000_8000, 0};
		send_request(it);
		it = '{rbi_pkg::SHAPE_CAPSULE, 32'h0001_0000, 0, 0, 0, 0, 32'h0004_0000};
		send_request(it);
		// smallest nonzero values, rounding to zero; the box saturates on two axes
		it = '{rbi_pkg::SHAPE_SPHERE, 32'd1, 0, 0, 0, 32'd1, 0};
		send_request(it);
		it = '{rbi_pkg::SHAPE_BOX, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 0, 0};
		send_request(it);
		// overflow on two axes while the third stays exact
		it = '{rbi_pkg::SHAPE_BOX, 32'h0100_0000, 32'd0, 32'd0, 32'h4000_0000, 0, 0};
		send_request(it);
	endtask

	// random requests, mostly valid shapes
	task automatic test_random(input int count);
		logic [1:0] shape;
		for (int i = 0; i < count; i++) begin
			shape = ($urandom_range(0, 19) == 0) ? rbi_pkg::SHAPE_BAD
				: 2'($urandom_range(0, 2));
			send_request(random_request(shape));
		end
	endtask

	initial begin
		int wait_cycles;
		error_count   = 0;
		request_count = 0;
		result_count  = 0;
		sat_count     = 0;
		cycle_count   = 0;
		exp_wr        = 0;
		exp_rd        = 0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.shape_kind = '0;
		in_ch.mass       = '0;
		in_ch.size_x     = '0;
		in_ch.size_y     = '0;
		in_ch.size_z     = '0;
		in_ch.radius     = '0;
		in_ch.cyl_height = '0;
		out_ch.ready     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1700);
		in_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		while (wait_cycles < 2 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		$display("%0d requests sent, %0d results checked, %0d saturated",
			request_count, result_count, sat_count);
		if (error_count == 0 && exp_wr == exp_rd)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> rigid_body_inertia_calc_top.f
sv/rbi_pkg.sv
sv/rbi_in_if.sv
sv/rbi_out_if.sv
sv/rbi_front.sv
sv/rbi_div_cell.sv
sv/rbi_out_buf.sv
sv/rigid_body_inertia_calc_top.sv
sim/rigid_body_inertia_calc_top_tb.sv
